// ----- rtl/core/sbms_pkg.sv -----
package sbms_pkg;

	localparam int WORD_W = 32;
	localparam int SID_W  = 3;

	// Request operation codes as they arrive on the func port.
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// Command as classified by the front end.
	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_POP,
		CMD_FULL,
		CMD_EMPTY
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [SID_W-1:0]  sid;
		logic [WORD_W-1:0] value;
	} item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_POP_HEAD,
		ST_POP
	} back_state_t;

endpackage

// ----- rtl/core/sbms_front.sv -----
module sbms_front import sbms_pkg::*; #(
	parameter int STACKS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              func,
	input  logic [SID_W-1:0]  stack_id,
	input  logic [WORD_W-1:0] value,
	output logic              q_vld,
	output item_t             q_item,
	input  logic              q_pop
);

	localparam int QDEPTH = 2;

	item_t            slot_q [QDEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             in_range;
	logic             push;
	item_t            item_in;

	// A stack number beyond the configured count behaves as a stack that is
	// always empty and never accepts a word.
	assign in_range = ({{(32-SID_W){1'b0}}, stack_id} < 32'(STACKS));

	always_comb begin
		item_in.sid   = stack_id;
		item_in.value = value;
		if (func == FUNC_POP) begin
			item_in.cmd = in_range ? CMD_POP : CMD_EMPTY;
		end else begin
			item_in.cmd = in_range ? CMD_PUSH : CMD_FULL;
		end
	end

	assign req_ready = (cnt_q != 2'(QDEPTH));
	assign push      = req_valid && req_ready;
	assign q_vld     = (cnt_q != 2'd0);
	assign q_item    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/core/sbms_back.sv -----
module sbms_back import sbms_pkg::*; #(
	parameter int ENTRIES = 64,
	parameter int STACKS  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_vld,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [1:0]        status,
	output logic [WORD_W-1:0] popped_value
);

	localparam int IW = $clog2(ENTRIES);
	localparam int LW = $clog2(ENTRIES + 1);
	localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
	localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

	logic [WORD_W-1:0] data_mem [ENTRIES];
	logic [LW-1:0]     link_mem [ENTRIES];
	logic [LW-1:0]     head_mem [STACKS];
	logic [STACKS-1:0] head_vld_q;

	back_state_t       state_q, state_d;
	logic [LW-1:0]     free_head_q;
	logic [LW-1:0]     fill_q;
	logic [SW-1:0]     sid_q;
	logic [WORD_W-1:0] value_q;
	logic              fresh_q;
	logic              hvld_q;
	logic [LW-1:0]     head_rd_q;
	logic [LW-1:0]     link_rd_q;
	logic [WORD_W-1:0] data_rd_q;
	logic [IW-1:0]     hidx_q;
	logic              res_vld_q;
	logic [1:0]        status_q;
	logic [WORD_W-1:0] popped_q;

	logic              out_free;
	logic [LW-1:0]     head_cur;
	logic [IW-1:0]     fh_idx;
	logic [SW-1:0]     q_sid;
	logic [LW-1:0]     next_free;
	logic              head_rd_en, push_rd_en, pop_rd_en;
	logic              wr_push, wr_pop;
	logic              res_ld;
	logic [1:0]        res_status;
	logic [WORD_W-1:0] res_data;

	assign out_free  = !res_vld_q || rsp_ready;
	assign head_cur  = hvld_q ? head_rd_q : NULL_LINK;
	assign fh_idx    = free_head_q[IW-1:0];
	assign q_sid     = SW'(q_item.sid);
	// Entries at or above the fill count have never been written and still
	// chain to their successor, so the link is known without a read.
	assign next_free = fresh_q ? (free_head_q + LW'(1)) : link_rd_q;

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		head_rd_en = 1'b0;
		push_rd_en = 1'b0;
		pop_rd_en  = 1'b0;
		wr_push    = 1'b0;
		wr_pop     = 1'b0;
		res_ld     = 1'b0;
		res_status = STATUS_DONE;
		res_data   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_vld) begin
					unique case (q_item.cmd)
						CMD_PUSH: begin
							if (free_head_q == NULL_LINK) begin
								if (out_free) begin
									q_pop      = 1'b1;
									res_ld     = 1'b1;
									res_status = STATUS_FULL;
								end
							end else begin
								q_pop      = 1'b1;
								head_rd_en = 1'b1;
								push_rd_en = 1'b1;
								state_d    = ST_PUSH;
							end
						end
						CMD_POP: begin
							q_pop      = 1'b1;
							head_rd_en = 1'b1;
							state_d    = ST_POP_HEAD;
						end
						CMD_FULL: begin
							if (out_free) begin
								q_pop      = 1'b1;
								res_ld     = 1'b1;
								res_status = STATUS_FULL;
							end
						end
						CMD_EMPTY: begin
							if (out_free) begin
								q_pop      = 1'b1;
								res_ld     = 1'b1;
								res_status = STATUS_EMPTY;
							end
						end
						default: ;
					endcase
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					wr_push = 1'b1;
					res_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_POP_HEAD: begin
				if (head_cur == NULL_LINK) begin
					if (out_free) begin
						res_ld     = 1'b1;
						res_status = STATUS_EMPTY;
						state_d    = ST_IDLE;
					end
				end else begin
					pop_rd_en = 1'b1;
					state_d   = ST_POP;
				end
			end
			ST_POP: begin
				if (out_free) begin
					wr_pop   = 1'b1;
					res_ld   = 1'b1;
					res_data = data_rd_q;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_push) begin
			head_mem[sid_q] <= free_head_q;
		end else if (wr_pop) begin
			head_mem[sid_q] <= link_rd_q;
		end
		if (head_rd_en) begin
			head_rd_q <= head_mem[q_sid];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_push) begin
			link_mem[fh_idx] <= head_cur;
		end else if (wr_pop) begin
			link_mem[hidx_q] <= free_head_q;
		end
		if (push_rd_en) begin
			link_rd_q <= link_mem[fh_idx];
		end else if (pop_rd_en) begin
			link_rd_q <= link_mem[head_cur[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_push) begin
			data_mem[fh_idx] <= value_q;
		end
		if (pop_rd_en) begin
			data_rd_q <= data_mem[head_cur[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sid_q   <= q_sid;
			value_q <= q_item.value;
		end
		if (pop_rd_en) begin
			hidx_q <= head_cur[IW-1:0];
		end
		if (res_ld) begin
			status_q <= res_status;
			popped_q <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_head_q <= '0;
			fill_q      <= '0;
			head_vld_q  <= '0;
			hvld_q      <= 1'b0;
			fresh_q     <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (head_rd_en) begin
				hvld_q <= head_vld_q[q_sid];
			end
			if (push_rd_en) begin
				fresh_q <= (free_head_q >= fill_q);
			end
			if (wr_push) begin
				head_vld_q[sid_q] <= 1'b1;
				free_head_q       <= next_free;
				if (fresh_q) begin
					fill_q <= fill_q + LW'(1);
				end
			end else if (wr_pop) begin
				free_head_q <= LW'(hidx_q);
			end
			if (res_ld) begin
				res_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = res_vld_q;
	assign status       = status_q;
	assign popped_value = popped_q;

endmodule

// ----- rtl/core/shared_buffer_multi_stack_core.sv -----
// Several LIFO stacks share one store of ENTRIES words; each request pushes a
// word onto, or pops a word from, one of STACKS stacks and returns one
// response word with a status. Requests are classified on entry and held in a
// two-word queue, so up to two requests are taken while the back end works.
// The back end handles one request at a time: a push reads the head and link
// stores, then writes; a pop reads the head, then the link and data stores,
// then writes; an empty pop ends after the head read and a request refused at
// once (full store or unknown stack) needs no read. The reads are registered
// and must return before the heads are updated. A finished response waits in
// an output register while the next request starts. No clearing pass runs
// after reset; requests are taken from the first cycle.
module shared_buffer_multi_stack_core import sbms_pkg::*; #(
	parameter int ENTRIES = 64,
	parameter int STACKS  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              func,
	input  logic [SID_W-1:0]  stack_id,
	input  logic [WORD_W-1:0] value,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [1:0]        status,
	output logic [WORD_W-1:0] popped_value
);

	logic  q_vld;
	logic  q_pop;
	item_t q_item;

	sbms_front #(
		.STACKS(STACKS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func     (func),
		.stack_id (stack_id),
		.value    (value),
		.q_vld    (q_vld),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	sbms_back #(
		.ENTRIES(ENTRIES),
		.STACKS (STACKS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_vld       (q_vld),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.popped_value(popped_value)
	);

endmodule

// ----- rtl/core/sbms_checker.sv -----
module sbms_checker import sbms_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [1:0]        status,
	input logic [WORD_W-1:0] popped_value
);

	// Words taken in but not yet answered.
	logic [2:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else begin
			cnt_q <= cnt_q + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
		end
	end

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != STATUS_DONE) |-> popped_value == '0)
		else $error("failed request returned a nonzero word");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(popped_value))
		else $error("stalled response changed");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cnt_q != 3'd0)
		else $error("response without an outstanding request");

	a_ready_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> cnt_q >= 3'd2)
		else $error("request refused with the queue not full");

endmodule

bind shared_buffer_multi_stack_core sbms_checker u_sbms_checker (.*);
